// File: hw/rtl/trapezoid_pulse_waveform_defines.svh
// ----------------------------------------------------------------------------
// Trapezoid pulse waveform assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_PULSE_WAVEFORM_DEFINES_SVH
`define TRAPEZOID_PULSE_WAVEFORM_DEFINES_SVH

// Same-cycle implication.
`define TPW_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tpw_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid pulse waveform package
// Widths, register indexes, phase codes and shared types.
// ----------------------------------------------------------------------------
package tpw_pkg;

  localparam int TIME_WIDTH    = 32;
  localparam int LEVEL_WIDTH   = 32;
  localparam int CFG_WIDTH     = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH;
  localparam int MAG_WIDTH     = LEVEL_WIDTH + 1;
  localparam int PROD_WIDTH    = TIME_WIDTH + MAG_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);
  localparam int MUL_CNT_WIDTH = $clog2(TIME_WIDTH + 1);
  localparam int CFG_IDX_WIDTH = 3;
  localparam int PHASE_WIDTH   = 3;

  typedef logic [CFG_IDX_WIDTH-1:0]        cfg_idx_t;
  typedef logic [PHASE_WIDTH-1:0]          phase_t;
  typedef logic [TIME_WIDTH-1:0]           time_t;
  typedef logic signed [LEVEL_WIDTH-1:0]   level_t;
  typedef logic [MAG_WIDTH-1:0]            mag_t;
  typedef logic [PROD_WIDTH-1:0]           prod_t;
  typedef logic [DIV_CNT_WIDTH-1:0]        div_cnt_t;
  typedef logic [MUL_CNT_WIDTH-1:0]        mul_cnt_t;

  localparam cfg_idx_t REG_DELAY  = 3'd0;
  localparam cfg_idx_t REG_RISE   = 3'd1;
  localparam cfg_idx_t REG_HIGH   = 3'd2;
  localparam cfg_idx_t REG_FALL   = 3'd3;
  localparam cfg_idx_t REG_PERIOD = 3'd4;
  localparam cfg_idx_t REG_BASE   = 3'd5;
  localparam cfg_idx_t REG_PEAK   = 3'd6;

  localparam phase_t PH_DELAY   = 3'd0;
  localparam phase_t PH_RISING  = 3'd1;
  localparam phase_t PH_HIGH    = 3'd2;
  localparam phase_t PH_FALLING = 3'd3;
  localparam phase_t PH_REST    = 3'd4;

  // Status of a serial arithmetic unit; done pulses for one cycle.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// File: hw/rtl/tpw_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add product of a time offset and a level magnitude, one bit a cycle.
// ----------------------------------------------------------------------------
module tpw_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tpw_pkg::time_t     mplier,
  input  tpw_pkg::mag_t      mcand,
  output tpw_pkg::unit_sts_t sts,
  output tpw_pkg::prod_t     product
);

  logic                                 busy_r, busy_nxt;
  logic                                 done_r, done_nxt;
  tpw_pkg::mul_cnt_t                    cnt_r, cnt_nxt;
  tpw_pkg::mag_t                        mcand_r;
  tpw_pkg::prod_t                       prod_r, prod_nxt;
  logic [tpw_pkg::MAG_WIDTH:0]          sum;

  always_comb begin
    // add multiplicand into the upper half when the low bit is set, then shift right
    sum = {1'b0, prod_r[tpw_pkg::PROD_WIDTH-1:tpw_pkg::TIME_WIDTH]}
        + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {sum, prod_r[tpw_pkg::TIME_WIDTH-1:1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tpw_pkg::mul_cnt_t'(tpw_pkg::TIME_WIDTH);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tpw_pkg::mul_cnt_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      prod_r  <= {{tpw_pkg::MAG_WIDTH{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = prod_r;

endmodule

// File: hw/rtl/tpw_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit a cycle; step count chosen per operation.
// ----------------------------------------------------------------------------
module tpw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tpw_pkg::prod_t     dividend,
  input  tpw_pkg::time_t     divisor,
  input  tpw_pkg::div_cnt_t  steps,
  output tpw_pkg::unit_sts_t sts,
  output tpw_pkg::prod_t     quotient,
  output tpw_pkg::time_t     remainder
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  tpw_pkg::div_cnt_t                 cnt_r, cnt_nxt;
  tpw_pkg::prod_t                    num_r;
  tpw_pkg::time_t                    rem_r, den_r;
  logic [tpw_pkg::TIME_WIDTH:0]      trial, trial_sub;
  logic                              ge;

  always_comb begin
    // shift in the next dividend bit, subtract when it fits
    trial     = {rem_r, num_r[tpw_pkg::PROD_WIDTH-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tpw_pkg::div_cnt_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[tpw_pkg::PROD_WIDTH-2:0], ge};
      rem_r <= ge ? trial_sub[tpw_pkg::TIME_WIDTH-1:0] : trial[tpw_pkg::TIME_WIDTH-1:0];
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/trapezoid_pulse_waveform.sv
// ----------------------------------------------------------------------------
// Trapezoid pulse waveform
// Level and phase of a repeating trapezoidal pulse at a sampled tick time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_time_ticks) takes one absolute time
//   per transaction. Output channel (out_valid/out_ready, out_level,
//   out_phase) returns exactly one result per input, in order.
//   Config port (cfg_we, cfg_index, cfg_wdata) writes the seven registers
//   delay, rise, high width, fall, period, base and peak; write only while
//   idle. Indexes beyond the list are ignored.
//   A time past the first period adds a pass through the shared divider
//   (remainder by the period). A sample on a ramp adds a serial multiply,
//   a serial divide and a final level step. One item is in work at a time;
//   the serial multiplier and the divider set the rate. A finished result
//   sits in the output register; the next input is taken meanwhile, and
//   its result holds in the sequencer until out_ready frees the register.
//   Reset clears the configuration registers to zero and empties the block.
// ----------------------------------------------------------------------------
`include "trapezoid_pulse_waveform_defines.svh"

module trapezoid_pulse_waveform (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tpw_pkg::TIME_WIDTH-1:0]      in_time_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpw_pkg::LEVEL_WIDTH-1:0] out_level,
  output logic [tpw_pkg::PHASE_WIDTH-1:0]     out_phase,
  input  logic                                cfg_we,
  input  logic [tpw_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [tpw_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

  localparam int LW = tpw_pkg::LEVEL_WIDTH;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_FOLDQ = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_RISE  = 4'd4;
  localparam logic [3:0] S_HIGH  = 4'd5;
  localparam logic [3:0] S_FALL  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_RDIV  = 4'd8;
  localparam logic [3:0] S_LVL   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // configuration registers
  tpw_pkg::time_t  delay_r, rise_r, high_r, fall_r, period_r;
  tpw_pkg::level_t base_r, peak_r;

  // sequencer state and working registers
  logic [3:0]          state_r, state_nxt;
  tpw_pkg::time_t      t_r, t_nxt;
  tpw_pkg::time_t      u_r, u_nxt;
  tpw_pkg::time_t      len_r, len_nxt;
  tpw_pkg::mag_t       diff_r, diff_nxt;
  tpw_pkg::mag_t       mag_r, mag_nxt;
  logic                rising_r, rising_nxt;
  logic [LW+1:0]       delta_r, delta_nxt;
  tpw_pkg::level_t     res_level_r, res_level_nxt;
  tpw_pkg::phase_t     res_phase_r, res_phase_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  tpw_pkg::level_t     out_level_r, out_level_nxt;
  tpw_pkg::phase_t     out_phase_r, out_phase_nxt;

  // serial arithmetic units
  logic                mul_start;
  tpw_pkg::unit_sts_t  mul_sts;
  tpw_pkg::prod_t      mul_product;
  logic                div_start;
  tpw_pkg::prod_t      div_dividend;
  tpw_pkg::time_t      div_divisor;
  tpw_pkg::div_cnt_t   div_steps;
  tpw_pkg::unit_sts_t  div_sts;
  tpw_pkg::prod_t      div_quot;
  tpw_pkg::time_t      div_rem;

  logic                diff_neg;
  logic [LW+1:0]       q_ext;
  logic [LW+1:0]       base_ext, peak_ext, lvl_wide;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

  // Config writes: ignore indexes past the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= '0;
      rise_r   <= '0;
      high_r   <= '0;
      fall_r   <= '0;
      period_r <= '0;
      base_r   <= '0;
      peak_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpw_pkg::REG_DELAY:  delay_r  <= cfg_wdata[tpw_pkg::TIME_WIDTH-1:0];
        tpw_pkg::REG_RISE:   rise_r   <= cfg_wdata[tpw_pkg::TIME_WIDTH-1:0];
        tpw_pkg::REG_HIGH:   high_r   <= cfg_wdata[tpw_pkg::TIME_WIDTH-1:0];
        tpw_pkg::REG_FALL:   fall_r   <= cfg_wdata[tpw_pkg::TIME_WIDTH-1:0];
        tpw_pkg::REG_PERIOD: period_r <= cfg_wdata[tpw_pkg::TIME_WIDTH-1:0];
        tpw_pkg::REG_BASE:   base_r   <= cfg_wdata[LW-1:0];
        tpw_pkg::REG_PEAK:   peak_r   <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // Sign of peak - base picks the ramp direction.
  assign diff_neg = diff_r[tpw_pkg::MAG_WIDTH-1];
  assign base_ext = {{2{base_r[LW-1]}}, base_r};
  assign peak_ext = {{2{peak_r[LW-1]}}, peak_r};
  // Quotient is below the magnitude, so its low MAG_WIDTH bits carry it all.
  assign q_ext    = {1'b0, div_quot[tpw_pkg::MAG_WIDTH-1:0]};
  assign lvl_wide = rising_r ? (base_ext + delta_r) : (peak_ext - delta_r);

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    len_nxt       = len_r;
    diff_nxt      = diff_r;
    mag_nxt       = mag_r;
    rising_nxt    = rising_r;
    delta_nxt     = delta_r;
    res_level_nxt = res_level_r;
    res_phase_nxt = res_phase_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    // fold divides (u-1) left-aligned for TIME_WIDTH steps; ramp divides the product
    if (state_r == S_FOLDQ) begin
      div_dividend = {u_r - 1'b1, {tpw_pkg::MAG_WIDTH{1'b0}}};
      div_divisor  = period_r;
      div_steps    = tpw_pkg::div_cnt_t'(tpw_pkg::TIME_WIDTH);
    end else begin
      div_dividend = mul_product;
      div_divisor  = len_r;
      div_steps    = tpw_pkg::div_cnt_t'(tpw_pkg::PROD_WIDTH);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          t_nxt     = in_time_ticks;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        diff_nxt = {peak_r[LW-1], peak_r} - {base_r[LW-1], base_r};
        if (t_r < delay_r) begin
          res_level_nxt = base_r;
          res_phase_nxt = tpw_pkg::PH_DELAY;
          state_nxt     = S_DONE;
        end else begin
          u_nxt     = t_r - delay_r;
          state_nxt = S_FOLDQ;
        end
      end
      S_FOLDQ: begin
        mag_nxt = diff_neg ? (~diff_r + 1'b1) : diff_r;
        // an offset equal to the period stays unfolded
        if ((period_r != '0) && (u_r > period_r)) begin
          div_start = 1'b1;
          state_nxt = S_FOLD;
        end else begin
          state_nxt = S_RISE;
        end
      end
      S_FOLD: begin
        if (div_sts.done) begin
          u_nxt     = div_rem + tpw_pkg::time_t'(1);
          state_nxt = S_RISE;
        end
      end
      S_RISE: begin
        if (u_r < rise_r) begin
          res_phase_nxt = tpw_pkg::PH_RISING;
          rising_nxt    = 1'b1;
          len_nxt       = rise_r;
          mul_start     = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          u_nxt     = u_r - rise_r;
          state_nxt = S_HIGH;
        end
      end
      S_HIGH: begin
        if (u_r < high_r) begin
          res_level_nxt = peak_r;
          res_phase_nxt = tpw_pkg::PH_HIGH;
          state_nxt     = S_DONE;
        end else begin
          u_nxt     = u_r - high_r;
          state_nxt = S_FALL;
        end
      end
      S_FALL: begin
        if (u_r < fall_r) begin
          res_phase_nxt = tpw_pkg::PH_FALLING;
          rising_nxt    = 1'b0;
          len_nxt       = fall_r;
          mul_start     = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          res_level_nxt = base_r;
          res_phase_nxt = tpw_pkg::PH_REST;
          state_nxt     = S_DONE;
        end
      end
      S_MUL: begin
        if (mul_sts.done) begin
          div_start = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_sts.done) begin
          // truncate toward zero: negate the magnitude quotient
          delta_nxt = diff_neg ? (~q_ext + 1'b1) : q_ext;
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        // ramp result lies between base and peak, so the low bits hold it
        res_level_nxt = lvl_wide[LW-1:0];
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: drop on handoff, load when the sequencer finishes.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = res_level_r;
      out_phase_nxt = res_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    u_r         <= u_nxt;
    len_r       <= len_nxt;
    diff_r      <= diff_nxt;
    mag_r       <= mag_nxt;
    rising_r    <= rising_nxt;
    delta_r     <= delta_nxt;
    res_level_r <= res_level_nxt;
    res_phase_r <= res_phase_nxt;
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
  end

  tpw_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mplier  (u_r),
    .mcand   (mag_r),
    .sts     (mul_sts),
    .product (mul_product)
  );

  tpw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .sts       (div_sts),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Divider finishes only while the sequencer waits on it.
  `TPW_ASSERT_IMPLIES(a_div_done_owner, div_sts.done, (state_r == S_FOLD) || (state_r == S_RDIV), "divider done outside a divide wait")
  // Multiplier finishes only in the multiply wait.
  `TPW_ASSERT_IMPLIES(a_mul_done_owner, mul_sts.done, state_r == S_MUL, "multiplier done outside multiply wait")
  // The two serial units never run at once.
  `TPW_ASSERT_IMPLIES(a_units_exclusive, mul_sts.busy, !div_sts.busy, "multiplier and divider busy together")
  // An accepted transaction always enters the delay check next.
  `TPW_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_r == S_CHK, "accepted input did not start")

endmodule
